FILE: rtl/core/vmp_pkg.sv
// shared constants for the vertex modelview/projection pipeline
package vmp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int NUM_COEFS = 18;
  localparam int IDX_W     = 5;

  // request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_VERTEX = 1'b1;

  // modelview layout: slot = row * MV_COLS + col, col 3 is translation
  localparam int MV_ROWS = 3;
  localparam int MV_COLS = 4;

  // projection coefficient slots
  localparam int CI_P0  = 12;
  localparam int CI_P5  = 13;
  localparam int CI_P8  = 14;
  localparam int CI_P9  = 15;
  localparam int CI_P10 = 16;
  localparam int CI_P14 = 17;

  // latency of the two units in register stages
  localparam int MUL_STAGES = 2;
  localparam int ROW_STAGES = 4;

endpackage

FILE: rtl/core/vertex_modelview_projection_top.sv
// path: an accepted vertex request passes the modelview rows, the projection multipliers and the output adders
// throughput: one vertex per cycle; the whole pipe holds while the output is stalled
// a load request writes the store at once and is taken only when no vertex is in flight
// loads yield no output
// reset: synchronous rst clears all 18 coefficients to zero and empties the pipe
module vertex_modelview_projection_top #(
  parameter int COORD_WIDTH = vmp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vmp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [vmp_pkg::IDX_W-1:0]     coef_index,
  input  logic signed [COORD_WIDTH-1:0] coef_value,
  input  logic signed [COORD_WIDTH-1:0] vert_x,
  input  logic signed [COORD_WIDTH-1:0] vert_y,
  input  logic signed [COORD_WIDTH-1:0] vert_z,
  input  logic                          vert_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic signed [COORD_WIDTH-1:0] out_w,
  output logic                          out_last
);

  localparam int DEPTH = vmp_pkg::ROW_STAGES + vmp_pkg::MUL_STAGES + 1;

  logic                          en;
  logic                          busy;
  logic                          take_vert;
  logic                          take_load;
  logic [DEPTH-1:0]              vld;
  logic [DEPTH-1:0]              lst;
  logic signed [COORD_WIDTH-1:0] coef [vmp_pkg::NUM_COEFS];
  logic signed [COORD_WIDTH-1:0] eye [vmp_pkg::MV_ROWS];
  logic signed [COORD_WIDTH-1:0] mx0;
  logic signed [COORD_WIDTH-1:0] mz8;
  logic signed [COORD_WIDTH-1:0] my5;
  logic signed [COORD_WIDTH-1:0] mz9;
  logic signed [COORD_WIDTH-1:0] mz10;
  logic signed [COORD_WIDTH-1:0] w5;
  logic signed [COORD_WIDTH-1:0] w6;
  logic signed [COORD_WIDTH-1:0] w7;

  assign en        = !vld[DEPTH-1] || out_ready;
  assign busy      = |vld;
  // a load waits for the pipe to drain so in-flight vertices keep their coefficients
  assign in_ready  = en && ((func == vmp_pkg::FUNC_VERTEX) || !busy);
  assign take_vert = in_valid && in_ready && (func == vmp_pkg::FUNC_VERTEX);
  assign take_load = in_valid && in_ready && (func == vmp_pkg::FUNC_LOAD);

  vmp_coef_store #(.COORD_WIDTH(COORD_WIDTH)) u_store (
    .clk(clk), .rst(rst), .we(take_load), .waddr(coef_index), .wdata(coef_value),
    .coef(coef)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], take_vert};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst <= {lst[DEPTH-2:0], vert_last};
    end
  end

  for (genvar r = 0; r < vmp_pkg::MV_ROWS; r++) begin : g_row
    vmp_row #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row (
      .clk(clk), .en(en),
      .x(vert_x), .y(vert_y), .z(vert_z),
      .m0(coef[r*vmp_pkg::MV_COLS + 0]),
      .m1(coef[r*vmp_pkg::MV_COLS + 1]),
      .m2(coef[r*vmp_pkg::MV_COLS + 2]),
      .m3(coef[r*vmp_pkg::MV_COLS + 3]),
      .e(eye[r])
    );
  end

  vmp_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_x0 (
    .clk(clk), .en(en), .a(eye[0]), .b(coef[vmp_pkg::CI_P0]), .p(mx0)
  );
  vmp_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_z8 (
    .clk(clk), .en(en), .a(eye[2]), .b(coef[vmp_pkg::CI_P8]), .p(mz8)
  );
  vmp_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_y5 (
    .clk(clk), .en(en), .a(eye[1]), .b(coef[vmp_pkg::CI_P5]), .p(my5)
  );
  vmp_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_z9 (
    .clk(clk), .en(en), .a(eye[2]), .b(coef[vmp_pkg::CI_P9]), .p(mz9)
  );
  vmp_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_z10 (
    .clk(clk), .en(en), .a(eye[2]), .b(coef[vmp_pkg::CI_P10]), .p(mz10)
  );

  // w = -ez, most negative saturates to most positive
  vmp_add #(.COORD_WIDTH(COORD_WIDTH)) u_neg_w (
    .clk(clk), .en(en), .sub(1'b1), .a('0), .b(eye[2]), .y(w5)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      w6 <= w5;
      w7 <= w6;
    end
  end

  vmp_add #(.COORD_WIDTH(COORD_WIDTH)) u_add_x (
    .clk(clk), .en(en), .sub(1'b0), .a(mx0), .b(mz8), .y(out_x)
  );
  vmp_add #(.COORD_WIDTH(COORD_WIDTH)) u_add_y (
    .clk(clk), .en(en), .sub(1'b0), .a(my5), .b(mz9), .y(out_y)
  );
  vmp_add #(.COORD_WIDTH(COORD_WIDTH)) u_add_z (
    .clk(clk), .en(en), .sub(1'b0), .a(mz10), .b(coef[vmp_pkg::CI_P14]), .y(out_z)
  );

  assign out_w     = w7;
  assign out_last  = lst[DEPTH-1];
  assign out_valid = vld[DEPTH-1];

  // coefficient writes never overlap a vertex in flight
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    take_load |-> !busy)
    else $error("load request accepted with vertices in flight");

  a_vert_enters: assert property (@(posedge clk) disable iff (rst)
    take_vert |=> vld[0])
    else $error("accepted vertex missing from first stage");

  a_load_no_slot: assert property (@(posedge clk) disable iff (rst)
    take_load |=> !vld[0])
    else $error("load request entered the pipe");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(vld) && $stable(lst))
    else $error("pipe moved during output stall");

endmodule

FILE: rtl/core/vmp_mul.sv
// two-stage fixed-point multiplier: split partial products, then sum, shift and saturate
module vmp_mul #(
  parameter int COORD_WIDTH = vmp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vmp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  output logic signed [COORD_WIDTH-1:0] p
);

  localparam int W  = COORD_WIDTH;
  localparam int L  = W / 2;
  localparam int PW = 2 * W;

  logic signed [W+L:0]    pp_lo;
  logic signed [PW-L-1:0] pp_hi;
  logic signed [W+L:0]    pp_lo_next;
  logic signed [PW-L-1:0] pp_hi_next;
  logic signed [PW-1:0]   lo_ext;
  logic signed [PW-1:0]   hi_ext;
  logic signed [PW-1:0]   full;
  logic signed [PW-1:0]   q;
  logic                   fits;
  logic signed [W-1:0]    p_next;

  // low half of b taken as unsigned, high half carries the sign
  assign pp_lo_next = a * $signed({1'b0, b[L-1:0]});
  assign pp_hi_next = a * $signed(b[W-1:L]);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo <= pp_lo_next;
      pp_hi <= pp_hi_next;
    end
  end

  assign lo_ext = {{(W-L-1){pp_lo[W+L]}}, pp_lo};
  assign hi_ext = {{L{pp_hi[PW-L-1]}}, pp_hi};
  assign full   = (hi_ext <<< L) + lo_ext;
  // arithmetic shift drops the fraction toward minus infinity
  assign q      = full >>> FRAC_BITS;
  assign fits   = (&q[PW-1:W-1]) | ~(|q[PW-1:W-1]);

  always_comb begin
    if (fits) begin
      p_next = q[W-1:0];
    end else if (q[PW-1]) begin
      p_next = {1'b1, {(W-1){1'b0}}};
    end else begin
      p_next = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_next;
    end
  end

endmodule

FILE: rtl/core/vmp_add.sv
// registered saturating add or subtract
module vmp_add #(
  parameter int COORD_WIDTH = vmp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          sub,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  output logic signed [COORD_WIDTH-1:0] y
);

  localparam int W = COORD_WIDTH;

  logic signed [W:0]   a_ext;
  logic signed [W:0]   b_ext;
  logic signed [W:0]   s;
  logic signed [W-1:0] y_next;

  assign a_ext = {a[W-1], a};
  assign b_ext = {b[W-1], b};
  assign s     = sub ? (a_ext - b_ext) : (a_ext + b_ext);

  always_comb begin
    if (s[W] == s[W-1]) begin
      y_next = s[W-1:0];
    end else if (s[W]) begin
      y_next = {1'b1, {(W-1){1'b0}}};
    end else begin
      y_next = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_next;
    end
  end

endmodule

FILE: rtl/core/vmp_coef_store.sv
// coefficient register file, cleared by reset, written by load requests
module vmp_coef_store #(
  parameter int COORD_WIDTH = vmp_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               we,
  input  logic [vmp_pkg::IDX_W-1:0]          waddr,
  input  logic signed [COORD_WIDTH-1:0]      wdata,
  output logic signed [COORD_WIDTH-1:0]      coef [vmp_pkg::NUM_COEFS]
);

  // slots beyond the store match no entry and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vmp_pkg::NUM_COEFS; i++) begin
        coef[i] <= '0;
      end
    end else if (we) begin
      for (int i = 0; i < vmp_pkg::NUM_COEFS; i++) begin
        if (waddr == vmp_pkg::IDX_W'(i)) begin
          coef[i] <= wdata;
        end
      end
    end
  end

endmodule

FILE: rtl/core/vmp_row.sv
// one modelview row: (x*m0 + y*m1) + (z*m2 + m3) over four stages
module vmp_row #(
  parameter int COORD_WIDTH = vmp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vmp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] z,
  input  logic signed [COORD_WIDTH-1:0] m0,
  input  logic signed [COORD_WIDTH-1:0] m1,
  input  logic signed [COORD_WIDTH-1:0] m2,
  input  logic signed [COORD_WIDTH-1:0] m3,
  output logic signed [COORD_WIDTH-1:0] e
);

  logic signed [COORD_WIDTH-1:0] px;
  logic signed [COORD_WIDTH-1:0] py;
  logic signed [COORD_WIDTH-1:0] pz;
  logic signed [COORD_WIDTH-1:0] sxy;
  logic signed [COORD_WIDTH-1:0] szt;

  vmp_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_x (
    .clk(clk), .en(en), .a(x), .b(m0), .p(px)
  );
  vmp_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_y (
    .clk(clk), .en(en), .a(y), .b(m1), .p(py)
  );
  vmp_mul #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_z (
    .clk(clk), .en(en), .a(z), .b(m2), .p(pz)
  );

  // translation is read straight from the store, which holds still while vertices are in flight
  vmp_add #(.COORD_WIDTH(COORD_WIDTH)) u_add_xy (
    .clk(clk), .en(en), .sub(1'b0), .a(px), .b(py), .y(sxy)
  );
  vmp_add #(.COORD_WIDTH(COORD_WIDTH)) u_add_zt (
    .clk(clk), .en(en), .sub(1'b0), .a(pz), .b(m3), .y(szt)
  );

  vmp_add #(.COORD_WIDTH(COORD_WIDTH)) u_add_e (
    .clk(clk), .en(en), .sub(1'b0), .a(sxy), .b(szt), .y(e)
  );

endmodule
